// ===== rtl/process_fifo_with_delete_by_key_top_defines.svh =====
// Assertion macros for the checker file of the process queue block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PROCESS_FIFO_WITH_DELETE_BY_KEY_TOP_DEFINES_SVH
`define PROCESS_FIFO_WITH_DELETE_BY_KEY_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFDK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PFDK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfdk_pkg.sv =====
// Package for the process queue block: command and result codes, field widths
// and parameter defaults. No dependencies.
`default_nettype none

package pfdk_pkg;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_DEL = 2'd2,
        CMD_CLR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_FULL      = 2'd1,
        RES_EMPTY     = 2'd2,
        RES_NOT_FOUND = 2'd3
    } res_t;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_REG_COUNT   = 4;
    localparam int MAX_REG_COUNT   = 4;
    localparam int ID_W            = 16;
    localparam int WORD_W          = 32;
    localparam int CNT_OUT_W       = 5;

endpackage

`default_nettype wire

// ===== rtl/pfdk_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfdk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/process_fifo_with_delete_by_key_top.sv =====
// Process queue with delete by id: top level.
// Depends on pfdk_pkg and pfdk_ram.
//
// Usage
// - Input channel (in_valid/in_ready) carries one command per transfer:
//   enqueue a record, dequeue the oldest, delete every record with a given
//   id, or clear. The record fields are only looked at for an enqueue, the
//   id also for a delete.
// - Output channel (out_valid/out_ready) returns exactly one result per
//   command: result code, the dequeued record (zero otherwise), occupancy
//   after the command and the number of records removed.
// - Sequencing: enqueue and clear go from the input transfer to S_RES,
//   dequeue through S_DEQ and then S_RES, delete through S_DEL and then
//   S_RES; S_RES loads the result into the output register. The record RAM
//   has one read and one write port; delete walks the queue one entry per
//   cycle, reading ahead and writing kept records down to close the gaps. A
//   new command is taken once the previous result is loaded, so the block
//   takes no new command while one is still in progress.
// - A finished result sits in the output register; a new command may be
//   taken while it waits. If the receiver stalls, the next result is held
//   back inside the block and no further command is taken.
// - Reset (rst_n low, asynchronous) empties the queue and drops any pending
//   result. The record RAM is not cleared; only data from written entries is used.
`default_nettype none

module process_fifo_with_delete_by_key_top
    import pfdk_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int REG_COUNT   = DEF_REG_COUNT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           cmd,
    input  wire logic [ID_W-1:0]      proc_id,
    input  wire logic [WORD_W-1:0]    status_word,
    input  wire logic [WORD_W-1:0]    page_table_base,
    input  wire logic [WORD_W-1:0]    reg_a,
    input  wire logic [WORD_W-1:0]    reg_b,
    input  wire logic [WORD_W-1:0]    reg_c,
    input  wire logic [WORD_W-1:0]    reg_d,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                result_code,
    output logic [ID_W-1:0]           out_proc_id,
    output logic [WORD_W-1:0]         out_status_word,
    output logic [WORD_W-1:0]         out_page_table,
    output logic [WORD_W-1:0]         out_reg_a,
    output logic [WORD_W-1:0]         out_reg_b,
    output logic [WORD_W-1:0]         out_reg_c,
    output logic [WORD_W-1:0]         out_reg_d,
    output logic [CNT_OUT_W-1:0]      occupancy,
    output logic [CNT_OUT_W-1:0]      removed_count
);

    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int REG_BASE = ID_W + 2 * WORD_W;
    localparam int REC_W    = REG_BASE + REG_COUNT * WORD_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_DEL,
        S_RES
    } state_t;

    // Physical slot of a queue position; base + pos stays below twice the depth.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(pos);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Control and pending-result registers
    state_t               state_reg,       state_next;
    logic [IDX_W-1:0]     head_reg,        head_next;
    logic [CNT_W-1:0]     count_reg,       count_next;
    logic [CNT_W-1:0]     pos_reg,         pos_next;
    logic [CNT_W-1:0]     kept_reg,        kept_next;
    logic [CNT_W-1:0]     removed_reg,     removed_next;
    logic [ID_W-1:0]      key_reg,         key_next;
    res_t                 p_code_reg,      p_code_next;
    logic [REC_W-1:0]     p_rec_reg,       p_rec_next;

    // Output register
    logic                 out_valid_reg,   out_valid_next;
    res_t                 out_code_reg,    out_code_next;
    logic [REC_W-1:0]     out_rec_reg,     out_rec_next;
    logic [CNT_OUT_W-1:0] out_occ_reg,     out_occ_next;
    logic [CNT_OUT_W-1:0] out_removed_reg, out_removed_next;

    // Record RAM ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [REC_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [REC_W-1:0]     ram_rdata;

    logic [WORD_W-1:0]    in_regs  [MAX_REG_COUNT];
    logic [WORD_W-1:0]    out_regs [MAX_REG_COUNT];
    logic [REC_W-1:0]     in_rec;

    // Delete scan helpers
    logic                 del_match;
    logic [CNT_W-1:0]     pos_inc;
    logic [CNT_W-1:0]     kept_upd;
    logic [CNT_W-1:0]     removed_upd;

    pfdk_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pack the incoming record: id, status, page table, then the saved registers
    assign in_regs[0] = reg_a;
    assign in_regs[1] = reg_b;
    assign in_regs[2] = reg_c;
    assign in_regs[3] = reg_d;

    always_comb
    begin
        in_rec                            = '0;
        in_rec[ID_W-1:0]                  = proc_id;
        in_rec[ID_W +: WORD_W]            = status_word;
        in_rec[ID_W + WORD_W +: WORD_W]   = page_table_base;
        for (int r = 0; r < REG_COUNT; r++)
        begin
            in_rec[REG_BASE + r * WORD_W +: WORD_W] = in_regs[r];
        end
    end

    // Unpack the output record; registers that are not stored read as zero
    for (genvar g = 0; g < MAX_REG_COUNT; g++)
    begin : g_out_regs
        if (g < REG_COUNT)
        begin : g_stored
            assign out_regs[g] = out_rec_reg[REG_BASE + g * WORD_W +: WORD_W];
        end
        else
        begin : g_unstored
            assign out_regs[g] = '0;
        end
    end

    assign del_match   = (ram_rdata[ID_W-1:0] == key_reg);
    assign pos_inc     = pos_reg + CNT_W'(1);
    assign kept_upd    = del_match ? kept_reg : kept_reg + CNT_W'(1);
    assign removed_upd = del_match ? removed_reg + CNT_W'(1) : removed_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        kept_next        = kept_reg;
        removed_next     = removed_reg;
        key_next         = key_reg;
        p_code_next      = p_code_reg;
        p_rec_next       = p_rec_reg;
        out_valid_next   = out_valid_reg;
        out_code_next    = out_code_reg;
        out_rec_next     = out_rec_reg;
        out_occ_next     = out_occ_reg;
        out_removed_next = out_removed_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_of(head_reg, count_reg);
        ram_wdata = in_rec;
        ram_raddr = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next     = proc_id;
                    removed_next = '0;
                    p_rec_next   = '0;
                    p_code_next  = RES_OK;
                    unique case (cmd_t'(cmd))
                        CMD_ENQ:
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                p_code_next = RES_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_RES;
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                p_code_next = RES_EMPTY;
                                state_next  = S_RES;
                            end
                            else
                            begin
                                state_next = S_DEQ;
                            end
                        end
                        CMD_DEL:
                        begin
                            if (count_reg == '0)
                            begin
                                p_code_next = RES_EMPTY;
                                state_next  = S_RES;
                            end
                            else
                            begin
                                pos_next   = '0;
                                kept_next  = '0;
                                state_next = S_DEL;
                            end
                        end
                        CMD_CLR:
                        begin
                            removed_next = count_reg;
                            count_next   = '0;
                            head_next    = '0;
                            state_next   = S_RES;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DEQ:
            begin
                p_rec_next = ram_rdata;
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = S_RES;
            end

            S_DEL:
            begin
                // Read data belongs to position pos_reg; a kept record moves
                // down to position kept_reg, which never passes the read ahead.
                if (!del_match && (kept_reg != pos_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(head_reg, kept_reg);
                    ram_wdata = ram_rdata;
                end
                ram_raddr    = slot_of(head_reg, pos_inc);
                pos_next     = pos_inc;
                kept_next    = kept_upd;
                removed_next = removed_upd;
                if (pos_inc == count_reg)
                begin
                    count_next  = kept_upd;
                    p_code_next = (removed_upd == '0) ? RES_NOT_FOUND : RES_OK;
                    state_next  = S_RES;
                end
            end

            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_code_next    = p_code_reg;
                    out_rec_next     = p_rec_reg;
                    out_occ_next     = CNT_OUT_W'(count_reg);
                    out_removed_next = CNT_OUT_W'(removed_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            pos_reg         <= '0;
            kept_reg        <= '0;
            removed_reg     <= '0;
            key_reg         <= '0;
            p_code_reg      <= RES_OK;
            p_rec_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_code_reg    <= RES_OK;
            out_rec_reg     <= '0;
            out_occ_reg     <= '0;
            out_removed_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            kept_reg        <= kept_next;
            removed_reg     <= removed_next;
            key_reg         <= key_next;
            p_code_reg      <= p_code_next;
            p_rec_reg       <= p_rec_next;
            out_valid_reg   <= out_valid_next;
            out_code_reg    <= out_code_next;
            out_rec_reg     <= out_rec_next;
            out_occ_reg     <= out_occ_next;
            out_removed_reg <= out_removed_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_code     = out_code_reg;
    assign out_proc_id     = out_rec_reg[ID_W-1:0];
    assign out_status_word = out_rec_reg[ID_W +: WORD_W];
    assign out_page_table  = out_rec_reg[ID_W + WORD_W +: WORD_W];
    assign out_reg_a       = out_regs[0];
    assign out_reg_b       = out_regs[1];
    assign out_reg_c       = out_regs[2];
    assign out_reg_d       = out_regs[3];
    assign occupancy       = out_occ_reg;
    assign removed_count   = out_removed_reg;

endmodule

`default_nettype wire

// ===== rtl/pfdk_checker.sv =====
// Port-level checker for the process queue block, bound to the top level.
// Depends on pfdk_pkg and process_fifo_with_delete_by_key_top_defines.svh.
`default_nettype none

`include "process_fifo_with_delete_by_key_top_defines.svh"

module pfdk_checker
    import pfdk_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [1:0]           result_code,
    input wire logic [ID_W-1:0]      out_proc_id,
    input wire logic [WORD_W-1:0]    out_status_word,
    input wire logic [WORD_W-1:0]    out_page_table,
    input wire logic [CNT_OUT_W-1:0] occupancy,
    input wire logic [CNT_OUT_W-1:0] removed_count
);

    localparam logic [CNT_OUT_W-1:0] FULL_OCC = CNT_OUT_W'(QUEUE_DEPTH);

    // Every command keeps the block busy in the cycle after its transfer
    `PFDK_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "command taken back to back")

    // A stalled result holds
    `PFDK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_code) && $stable(out_proc_id) && $stable(occupancy) && $stable(removed_count), "stalled result changed")

    // Full is only reported with the queue at capacity
    `PFDK_ASSERT_SAME(a_full_occ, out_valid && (result_code == RES_FULL), (occupancy == FULL_OCC) && (removed_count == '0), "full reported below capacity")

    // Failed commands carry no record
    `PFDK_ASSERT_SAME(a_fail_no_rec, out_valid && (result_code != RES_OK), (out_proc_id == '0) && (out_status_word == '0) && (out_page_table == '0), "record on failed command")

    // Empty and not found remove nothing; empty leaves nothing held
    `PFDK_ASSERT_SAME(a_fail_no_remove, out_valid && ((result_code == RES_EMPTY) || (result_code == RES_NOT_FOUND)), (removed_count == '0) && ((result_code != RES_EMPTY) || (occupancy == '0)), "bad counts on failed command")

endmodule

bind process_fifo_with_delete_by_key_top pfdk_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pfdk_checker (.*);

`default_nettype wire
